// ===== src/iqap_pkg.sv =====
package iqap_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int AMP_W = 16;
   localparam int PHASE_W = 15;
   localparam int AMP_FRAC = 4;

   // cordic setup
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_PRESHIFT = 16;
   localparam int CORDIC_W = 32;
   localparam int ANGLE_FRAC = 30;
   localparam int PHASE_FRAC = 13;
   localparam int ANGLE_SHIFT = ANGLE_FRAC - PHASE_FRAC;
   localparam int ROUND_W = CORDIC_W + 1 - ANGLE_SHIFT;
   localparam int ROUND_HALF = 1 << (ANGLE_SHIFT - 1);

   // square root setup
   localparam int CENTER_W = SAMPLE_W + 1;
   localparam int SUMSQ_W = 2 * SAMPLE_W + 1;
   localparam int RAD_W = SUMSQ_W + 2 * AMP_FRAC;
   localparam int ROOT_W = (RAD_W + 1) / 2;

   localparam logic [SAMPLE_W-1:0] MID_SCALE_RESET = 12'd2047;
   localparam logic signed [PHASE_W-1:0] PHASE_HALF_PI = 15'sd12868;

   // flags that ride along with each word
   typedef struct packed {
      logic last;
      logic q_zero;
      logic i_zero;
      logic negate;
   } iqap_tag_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } iqap_cordic_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } iqap_sqrt_type;

   // floor(atan(2^-k) * 2^30)
   function automatic logic signed [CORDIC_W-1:0] iqap_atan(input int k);
      logic signed [CORDIC_W-1:0] a;
      case (k)
         0:  a = 32'sd843314856;
         1:  a = 32'sd497837829;
         2:  a = 32'sd263043836;
         3:  a = 32'sd133525158;
         4:  a = 32'sd67021686;
         5:  a = 32'sd33543515;
         6:  a = 32'sd16775850;
         7:  a = 32'sd8388437;
         8:  a = 32'sd4194282;
         9:  a = 32'sd2097149;
         10: a = 32'sd1048575;
         11: a = 32'sd524287;
         12: a = 32'sd262143;
         13: a = 32'sd131071;
         14: a = 32'sd65535;
         15: a = 32'sd32767;
         16: a = 32'sd16383;
         17: a = 32'sd8191;
         18: a = 32'sd4095;
         19: a = 32'sd2047;
         20: a = 32'sd1023;
         21: a = 32'sd511;
         22: a = 32'sd255;
         23: a = 32'sd127;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/iqap_ifs.sv =====
// sample pair channel
interface iqap_req_if import iqap_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] i_sample;
   logic [SAMPLE_W-1:0] q_sample;
   logic                last_in;

   modport source (output valid, output i_sample, output q_sample, output last_in,
                   input ready);
   modport sink (input valid, input i_sample, input q_sample, input last_in,
                 output ready);
endinterface

// amplitude and phase channel
interface iqap_rsp_if import iqap_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [AMP_W-1:0]          amplitude;
   logic signed [PHASE_W-1:0] phase;
   logic                      last_out;

   modport source (output valid, output amplitude, output phase, output last_out,
                   input ready);
   modport sink (input valid, input amplitude, input phase, input last_out,
                 output ready);
endinterface

// ===== src/iqap_cordic_stage.sv =====
module iqap_cordic_stage import iqap_pkg::*; #(
   parameter int STAGE_IDX = 0,
   parameter bit ACTIVE = 1'b1
) (
   input  logic            clock,
   input  logic            enable,
   input  iqap_tag_type    tag_d,
   input  iqap_cordic_type cordic_d,
   output iqap_tag_type    tag_q,
   output iqap_cordic_type cordic_q
);

   localparam logic signed [CORDIC_W-1:0] ANGLE = iqap_atan(STAGE_IDX);

   iqap_tag_type    tag_ff;
   iqap_cordic_type cordic_ff;
   iqap_cordic_type cordic_in;
   logic signed [CORDIC_W-1:0] x_shift;
   logic signed [CORDIC_W-1:0] y_shift;

   assign x_shift = $signed(cordic_d.x) >>> STAGE_IDX;
   assign y_shift = $signed(cordic_d.y) >>> STAGE_IDX;

   // one vectoring rotation, driving y toward zero
   always_comb begin
      cordic_in = cordic_d;
      if (ACTIVE) begin
         if (!cordic_d.y[CORDIC_W-1]) begin
            cordic_in.x = cordic_d.x + y_shift;
            cordic_in.y = cordic_d.y - x_shift;
            cordic_in.z = cordic_d.z + ANGLE;
         end else begin
            cordic_in.x = cordic_d.x - y_shift;
            cordic_in.y = cordic_d.y + x_shift;
            cordic_in.z = cordic_d.z - ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tag_ff    <= tag_d;
         cordic_ff <= cordic_in;
      end
   end

   assign tag_q    = tag_ff;
   assign cordic_q = cordic_ff;

endmodule

// ===== src/iqap_sqrt_stage.sv =====
module iqap_sqrt_stage import iqap_pkg::*; #(
   parameter int BIT_IDX = 0,
   parameter bit ACTIVE = 1'b1
) (
   input  logic          clock,
   input  logic          enable,
   input  iqap_sqrt_type sqrt_d,
   output iqap_sqrt_type sqrt_q
);

   localparam int TRIAL_W = RAD_W + 1;

   iqap_sqrt_type      sqrt_ff;
   iqap_sqrt_type      sqrt_in;
   logic [TRIAL_W-1:0] trial;
   logic [TRIAL_W-1:0] rem_ext;
   logic [TRIAL_W-1:0] diff;

   // (root + 2^b)^2 - root^2, root holding only bits above b
   assign trial   = (TRIAL_W'(sqrt_d.root) << (BIT_IDX + 1))
                  | (TRIAL_W'(1) << (2 * BIT_IDX));
   assign rem_ext = TRIAL_W'(sqrt_d.rem);
   assign diff    = rem_ext - trial;

   // decide one root bit
   always_comb begin
      sqrt_in = sqrt_d;
      if (ACTIVE && (rem_ext >= trial)) begin
         sqrt_in.rem  = diff[RAD_W-1:0];
         sqrt_in.root = sqrt_d.root | (ROOT_W'(1) << BIT_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sqrt_ff <= sqrt_in;
      end
   end

   assign sqrt_q = sqrt_ff;

endmodule

// ===== src/iqap_front.sv =====
module iqap_front import iqap_pkg::*; (
   input  logic                clock,
   input  logic                enable,
   input  logic [SAMPLE_W-1:0] i_sample,
   input  logic [SAMPLE_W-1:0] q_sample,
   input  logic                last_in,
   input  logic [SAMPLE_W-1:0] mid_scale,
   output iqap_tag_type        tag_out,
   output iqap_sqrt_type       sqrt_out,
   output iqap_cordic_type     cordic_out
);

   logic signed [CENTER_W-1:0] i_cent;
   logic signed [CENTER_W-1:0] q_cent;
   logic signed [CENTER_W-1:0] i_abs;
   logic signed [CENTER_W-1:0] q_abs;
   iqap_tag_type               tag_in;
   logic [SAMPLE_W-1:0]        ai_ff;
   logic [SAMPLE_W-1:0]        aq_ff;
   iqap_tag_type               tag1_ff;
   logic [2*SAMPLE_W-1:0]      i_sq;
   logic [2*SAMPLE_W-1:0]      q_sq;
   logic [SUMSQ_W-1:0]         sumsq;
   iqap_sqrt_type              sqrt_in;
   iqap_cordic_type            cordic_in;
   iqap_tag_type               tag2_ff;
   iqap_sqrt_type              sqrt_ff;
   iqap_cordic_type            cordic_ff;

   // center both codes and fold to magnitude
   assign i_cent = $signed({1'b0, i_sample}) - $signed({1'b0, mid_scale});
   assign q_cent = $signed({1'b0, q_sample}) - $signed({1'b0, mid_scale});
   assign i_abs  = i_cent[CENTER_W-1] ? -i_cent : i_cent;
   assign q_abs  = q_cent[CENTER_W-1] ? -q_cent : q_cent;

   always_comb begin
      tag_in.last   = last_in;
      tag_in.q_zero = (q_cent == '0);
      tag_in.i_zero = (i_cent == '0);
      tag_in.negate = i_cent[CENTER_W-1] ^ q_cent[CENTER_W-1];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ai_ff   <= i_abs[SAMPLE_W-1:0];
         aq_ff   <= q_abs[SAMPLE_W-1:0];
         tag1_ff <= tag_in;
      end
   end

   // sum of squares and cordic start vector (x = |q|, y = |i|)
   assign i_sq  = ai_ff * ai_ff;
   assign q_sq  = aq_ff * aq_ff;
   assign sumsq = {1'b0, i_sq} + {1'b0, q_sq};

   always_comb begin
      sqrt_in.rem    = {sumsq, {(2*AMP_FRAC){1'b0}}};
      sqrt_in.root   = '0;
      cordic_in.x    = $signed(CORDIC_W'({aq_ff, {CORDIC_PRESHIFT{1'b0}}}));
      cordic_in.y    = $signed(CORDIC_W'({ai_ff, {CORDIC_PRESHIFT{1'b0}}}));
      cordic_in.z    = '0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tag2_ff   <= tag1_ff;
         sqrt_ff   <= sqrt_in;
         cordic_ff <= cordic_in;
      end
   end

   assign tag_out    = tag2_ff;
   assign sqrt_out   = sqrt_ff;
   assign cordic_out = cordic_ff;

endmodule

// ===== src/iqap_back.sv =====
module iqap_back import iqap_pkg::*; (
   input  logic                      clock,
   input  logic                      enable,
   input  iqap_tag_type              tag_d,
   input  iqap_sqrt_type             sqrt_d,
   input  iqap_cordic_type           cordic_d,
   output logic [AMP_W-1:0]          amplitude,
   output logic signed [PHASE_W-1:0] phase,
   output logic                      last_out
);

   logic [CORDIC_W:0]         z_round;
   logic [ROUND_W-1:0]        z_q;
   logic [PHASE_W-1:0]        mag;
   logic [AMP_W-1:0]          amp_in;
   logic signed [PHASE_W-1:0] phase_in;
   logic [AMP_W-1:0]          amp_ff;
   logic signed [PHASE_W-1:0] phase_ff;
   logic                      last_ff;

   // round half up to the output fraction
   assign z_round = {cordic_d.z[CORDIC_W-1], cordic_d.z} + (CORDIC_W+1)'(ROUND_HALF);
   assign z_q     = z_round[CORDIC_W:ANGLE_SHIFT];

   // clamp to 0..pi/2
   always_comb begin
      if (z_q[ROUND_W-1]) begin
         mag = '0;
      end else if (z_q > ROUND_W'(PHASE_HALF_PI)) begin
         mag = PHASE_HALF_PI;
      end else begin
         mag = z_q[PHASE_W-1:0];
      end
   end

   // axis cases and quadrant sign
   always_comb begin
      if (tag_d.q_zero) begin
         phase_in = PHASE_HALF_PI;
      end else if (tag_d.i_zero) begin
         phase_in = '0;
      end else if (tag_d.negate) begin
         phase_in = -$signed(mag);
      end else begin
         phase_in = $signed(mag);
      end
   end

   // saturate the root to the amplitude width
   assign amp_in = (sqrt_d.root[ROOT_W-1:AMP_W] != '0) ? {AMP_W{1'b1}}
                                                      : sqrt_d.root[AMP_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         amp_ff   <= amp_in;
         phase_ff <= phase_in;
         last_ff  <= tag_d.last;
      end
   end

   assign amplitude = amp_ff;
   assign phase     = phase_ff;
   assign last_out  = last_ff;

endmodule

// ===== src/iq_to_amplitude_phase_unit.sv =====
// a word passes the front registers, the rotation and root stages, then iqap_back
// throughput: one word per cycle unless the result is held; the cordic and
//   17-stage root pipelines run side by side, the longer one sets the depth
// a stalled result holds the whole pipeline, nothing is dropped or repeated
// reset (synchronous, active high) empties the pipeline and sets the offset to 2047
module iq_to_amplitude_phase_unit import iqap_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input logic                clock,
   input logic                reset,
   iqap_req_if.sink           req,
   iqap_rsp_if.source         rsp,
   input logic                csr_we,
   input logic [SAMPLE_W-1:0] csr_wdata
);

   localparam int PIPE_LEN = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;
   localparam int NSTAGE = PIPE_LEN + 3;

   logic [SAMPLE_W-1:0] mid_scale_ff;
   logic [NSTAGE-1:0]   valid_ff;
   logic [NSTAGE-1:0]   valid_in;
   logic                pipe_en;
   iqap_tag_type        tag_chain    [0:PIPE_LEN];
   iqap_sqrt_type       sqrt_chain   [0:PIPE_LEN];
   iqap_cordic_type     cordic_chain [0:PIPE_LEN];

   // offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_scale_ff <= MID_SCALE_RESET;
      end else if (csr_we) begin
         mid_scale_ff <= csr_wdata;
      end
   end

   // whole pipeline moves unless the result is held
   assign pipe_en   = !valid_ff[NSTAGE-1] || rsp.ready;
   assign req.ready = pipe_en;

   // valid bits travel with the data
   assign valid_in = {valid_ff[NSTAGE-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   iqap_front u_front (
      .clock      (clock),
      .enable     (pipe_en),
      .i_sample   (req.i_sample),
      .q_sample   (req.q_sample),
      .last_in    (req.last_in),
      .mid_scale  (mid_scale_ff),
      .tag_out    (tag_chain[0]),
      .sqrt_out   (sqrt_chain[0]),
      .cordic_out (cordic_chain[0])
   );

   // rotation and root bit stages
   for (genvar s = 0; s < PIPE_LEN; s++) begin : g_stage
      localparam int SQ_BIT = (s < ROOT_W) ? ROOT_W - 1 - s : 0;

      iqap_cordic_stage #(
         .STAGE_IDX (s),
         .ACTIVE    (s < CORDIC_STAGES)
      ) u_cordic (
         .clock    (clock),
         .enable   (pipe_en),
         .tag_d    (tag_chain[s]),
         .cordic_d (cordic_chain[s]),
         .tag_q    (tag_chain[s+1]),
         .cordic_q (cordic_chain[s+1])
      );

      iqap_sqrt_stage #(
         .BIT_IDX (SQ_BIT),
         .ACTIVE  (s < ROOT_W)
      ) u_sqrt (
         .clock  (clock),
         .enable (pipe_en),
         .sqrt_d (sqrt_chain[s]),
         .sqrt_q (sqrt_chain[s+1])
      );
   end

   iqap_back u_back (
      .clock     (clock),
      .enable    (pipe_en),
      .tag_d     (tag_chain[PIPE_LEN]),
      .sqrt_d    (sqrt_chain[PIPE_LEN]),
      .cordic_d  (cordic_chain[PIPE_LEN]),
      .amplitude (rsp.amplitude),
      .phase     (rsp.phase),
      .last_out  (rsp.last_out)
   );

   assign rsp.valid = valid_ff[NSTAGE-1];

endmodule

// ===== src/iqap_checker.sv =====
module iqap_checker import iqap_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [AMP_W-1:0]          rsp_amplitude,
   input logic signed [PHASE_W-1:0] rsp_phase,
   input logic                      rsp_last_out
);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a held result blocks the input side
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input ready while result is held");

   // a held result keeps its word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_amplitude)
         && $stable(rsp_phase) && $stable(rsp_last_out)))
      else $error("held result changed");

   // phase stays within -pi/2..pi/2
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_phase >= -PHASE_HALF_PI) && (rsp_phase <= PHASE_HALF_PI)))
      else $error("phase out of range");

   // zero amplitude means centered q is zero, so phase is pi/2
   a_zero_amp_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_amplitude == '0)) |-> (rsp_phase == PHASE_HALF_PI))
      else $error("zero amplitude with phase other than pi/2");

endmodule

bind iq_to_amplitude_phase_unit iqap_checker u_iqap_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_amplitude (rsp.amplitude),
   .rsp_phase     (rsp.phase),
   .rsp_last_out  (rsp.last_out)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import iqap_pkg::*;

   localparam int CORDIC_STAGES = CORDIC_STAGES_DEF;
   localparam int PIPE_LATENCY = (CORDIC_STAGES > 17 ? CORDIC_STAGES : 17) + 3;
   localparam int STALL_LIMIT = 1000;
   localparam longint HALF_PI_Q13 = 12868;
   localparam longint AMP_SAT = 65535;

   typedef struct packed {
      logic [AMP_W-1:0]          amplitude;
      logic signed [PHASE_W-1:0] phase;
      logic                      last;
   } amp_phase_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_BURSTS
   } ready_mode_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [SAMPLE_W-1:0] csr_wdata;

   iqap_req_if req();
   iqap_rsp_if rsp();

   // arctangent of 2^-k with 30 fraction bits
   longint atan_q30 [0:23] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
   };

   logic [SAMPLE_W-1:0] offset_now = MID_SCALE_RESET;
   amp_phase_type       expected_words[$];
   int                  error_count = 0;
   int                  idle_cycles = 0;
   ready_mode_type      ready_mode = READY_ALWAYS;
   int                  mode_age = 0;
   int                  stall_left = 0;

   always #5 clock = ~clock;

   iq_to_amplitude_phase_unit #(.CORDIC_STAGES(CORDIC_STAGES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // amplitude, phase and last flag expected for one sample pair
   function automatic amp_phase_type amp_phase_of(input logic [SAMPLE_W-1:0] i_code,
                                                  input logic [SAMPLE_W-1:0] q_code,
                                                  input logic last,
                                                  input logic [SAMPLE_W-1:0] offset);
      longint          ic, qc, x, y, z, xs, ys;
      longint unsigned rad, root, probe;
      amp_phase_type   r;
      ic = longint'(i_code) - longint'(offset);
      qc = longint'(q_code) - longint'(offset);

      // exact root of the scaled sum of squares, floor
      rad = longint'((ic * ic + qc * qc) * 256);
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rad)
         probe >>= 2;
      while (probe != 0) begin
         if (rad >= root + probe) begin
            rad -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      r.amplitude = (root > AMP_SAT) ? AMP_SAT[AMP_W-1:0] : root[AMP_W-1:0];

      // atan(i/q) by vectoring on magnitudes, sign applied afterwards
      if (qc == 0) begin
         z = HALF_PI_Q13;
      end else if (ic == 0) begin
         z = 0;
      end else begin
         x = (qc < 0 ? -qc : qc) << CORDIC_PRESHIFT;
         y = (ic < 0 ? -ic : ic) << CORDIC_PRESHIFT;
         z = 0;
         for (int k = 0; k < CORDIC_STAGES && k < 24; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + atan_q30[k];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - atan_q30[k];
            end
         end
         z = (z + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
         if (z < 0)
            z = 0;
         if (z > HALF_PI_Q13)
            z = HALF_PI_Q13;
         if ((ic < 0) != (qc < 0))
            z = -z;
      end
      r.phase = z[PHASE_W-1:0];
      r.last = last;
      return r;
   endfunction

   // compare each result word with the oldest expectation, then log new pairs
   always @(posedge clock) begin : check_words
      amp_phase_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.amplitude = rsp.amplitude;
         got.phase = rsp.phase;
         got.last = rsp.last_out;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none actual amp %0d phase %0d last %0b",
                     $time, got.amplitude, got.phase, got.last);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (got.amplitude !== want.amplitude) begin
               $display("%0t: amplitude mismatch, expected %0d actual %0d",
                        $time, want.amplitude, got.amplitude);
               error_count++;
            end
            if (got.phase !== want.phase) begin
               $display("%0t: phase mismatch, expected %0d actual %0d",
                        $time, want.phase, got.phase);
               error_count++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last flag mismatch, expected %0b actual %0b",
                        $time, want.last, got.last);
               error_count++;
            end
         end
      end
      if (!reset && req.valid && req.ready)
         expected_words.push_back(amp_phase_of(req.i_sample, req.q_sample, req.last_in,
                                               offset_now));
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("iq_to_amplitude_phase_unit verification failed");
         $finish;
      end
   end

   // result side back-pressure, in modes picked at random from time to time
   always @(posedge clock) begin : rsp_stall_pattern
      if (mode_age == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_age = $urandom_range(50, 400);
      end
      mode_age--;
      if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left--;
      end else begin
         case (ready_mode)
            READY_ALWAYS: rsp.ready <= 1'b1;
            READY_COIN:   rsp.ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp.ready <= 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_left = $urandom_range(1, 12);
            end
         endcase
      end
   end

   // present one pair and hold it until taken
   task automatic send_word(input logic [SAMPLE_W-1:0] i_code,
                            input logic [SAMPLE_W-1:0] q_code,
                            input logic last);
      req.valid <= 1'b1;
      req.i_sample <= i_code;
      req.q_sample <= q_code;
      req.last_in <= last;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold the sender until every expected word has come back
   task automatic wait_all_results;
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_offset(input logic [SAMPLE_W-1:0] value);
      wait_all_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      offset_now = value;
   endtask

   // bursts of random pairs, some pinned to the offset or near it
   task automatic send_random_words(input int count);
      int                  burst;
      int                  pick;
      logic [SAMPLE_W-1:0] i_code, q_code;
      burst = $urandom_range(1, 64);
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            pause_sender($urandom_range(1, 16));
            burst = $urandom_range(1, 64);
         end
         pick = $urandom_range(0, 19);
         i_code = SAMPLE_W'($urandom_range(0, 4095));
         q_code = SAMPLE_W'($urandom_range(0, 4095));
         case (pick)
            0: i_code = offset_now;
            1: q_code = offset_now;
            2: begin
               i_code = offset_now;
               q_code = offset_now;
            end
            3: begin
               i_code = SAMPLE_W'(offset_now + $urandom_range(0, 6) - 3);
               q_code = SAMPLE_W'(offset_now + $urandom_range(0, 6) - 3);
            end
            default: ;
         endcase
         send_word(i_code, q_code, $urandom_range(0, 15) == 0);
         burst--;
      end
   endtask

   // reset offset, zero axes, corners and tiny angles
   task automatic test_directed_mid_scale;
      send_word(12'd2047, 12'd2047, 1'b0);
      send_word(12'd4095, 12'd2047, 1'b1);
      send_word(12'd0,    12'd2047, 1'b0);
      send_word(12'd2047, 12'd4095, 1'b1);
      send_word(12'd2047, 12'd0,    1'b0);
      send_word(12'd4095, 12'd4095, 1'b0);
      send_word(12'd0,    12'd0,    1'b1);
      send_word(12'd4095, 12'd0,    1'b0);
      send_word(12'd0,    12'd4095, 1'b0);
      send_word(12'd2048, 12'd2046, 1'b0);
      send_word(12'd2046, 12'd2048, 1'b1);
      send_word(12'd2048, 12'd4095, 1'b0);
      send_word(12'd4095, 12'd2048, 1'b0);
      send_word(12'd2049, 12'd2049, 1'b1);
   endtask

   // offsets at both ends, where the amplitude saturates
   task automatic test_directed_offset_extremes;
      write_offset(12'd0);
      send_word(12'd4095, 12'd4095, 1'b0);
      send_word(12'd0,    12'd0,    1'b1);
      send_word(12'd4095, 12'd0,    1'b0);
      send_word(12'd0,    12'd4095, 1'b0);
      send_word(12'd1,    12'd1,    1'b1);
      send_word(12'd2900, 12'd2900, 1'b0);
      write_offset(12'd4095);
      send_word(12'd0,    12'd0,    1'b0);
      send_word(12'd4095, 12'd4095, 1'b1);
      send_word(12'd0,    12'd4094, 1'b0);
      send_word(12'd4094, 12'd0,    1'b0);
      send_word(12'd4095, 12'd0,    1'b1);
   endtask

   task automatic test_random_mid_scale;
      write_offset(MID_SCALE_RESET);
      send_random_words(450);
      wait_all_results();
      send_random_words(450);
   endtask

   task automatic test_random_offset_extremes;
      write_offset(12'd0);
      send_random_words(200);
      write_offset(12'd4095);
      send_random_words(200);
   endtask

   task automatic test_random_offsets;
      repeat (3) begin
         write_offset(SAMPLE_W'($urandom_range(0, 4095)));
         send_random_words(150);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.i_sample <= '0;
      req.q_sample <= '0;
      req.last_in <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_mid_scale();
      test_directed_offset_extremes();
      test_random_mid_scale();
      test_random_offset_extremes();
      test_random_offsets();

      // drain, then give any stray word time to show up
      wait_all_results();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (error_count == 0)
         $display("iq_to_amplitude_phase_unit verification clean");
      else
         $display("iq_to_amplitude_phase_unit verification failed");
      $finish;
   end

endmodule
